// File: hdl/mrc_pkg.sv
`default_nettype none

package mrc_pkg;

	localparam int MAX_FRAME_BYTES = 32;
	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int MIN_FRAME_BYTES = 7;

	typedef logic [CNT_W-1:0] count_t;

	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic signed [15:0] FAIL_READING = 16'sh8000;

	localparam logic [7:0] RESET_ADDRESS = 8'h01;
	localparam logic [7:0] RESET_FUNCTION = 8'h03;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_SHORT  = 2'd1,
		ST_HEADER = 2'd2,
		ST_CRC    = 2'd3
	} check_status_t;

	typedef enum logic {
		REG_EXPECTED_ADDRESS  = 1'b0,
		REG_EXPECTED_FUNCTION = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		check_status_t      status;
		logic signed [15:0] reading;
	} frame_result_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

// File: hdl/mrc_frame_track.sv
`default_nettype none

module mrc_frame_track (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [7:0]           rx_byte,
	input  wire logic                 frame_end,
	input  wire logic [7:0]           expected_address,
	input  wire logic [7:0]           expected_function,
	output mrc_pkg::frame_result_t    result
);

	logic [15:0]     crc_q, crc_nx;
	mrc_pkg::count_t count_q, count_nx;
	logic [15:0]     pair_q, pair_nx;
	logic            header_q, header_nx;
	logic [15:0]     value_q, value_nx;
	logic            take;
	logic [15:0]     received;

	always_comb begin
		take = count_q < mrc_pkg::count_t'(mrc_pkg::MAX_FRAME_BYTES);
		crc_nx = crc_q;
		count_nx = count_q;
		pair_nx = pair_q;
		header_nx = header_q;
		value_nx = value_q;
		if (take) begin
			if (count_q >= mrc_pkg::count_t'(2)) begin
				crc_nx = mrc_pkg::crc_byte(crc_q, pair_q[15:8]);
			end
			pair_nx = {pair_q[7:0], rx_byte};
			if (count_q == mrc_pkg::count_t'(0) && rx_byte != expected_address) begin
				header_nx = 1'b0;
			end
			if (count_q == mrc_pkg::count_t'(1) && rx_byte != expected_function) begin
				header_nx = 1'b0;
			end
			if (count_q == mrc_pkg::count_t'(3)) begin
				value_nx[15:8] = rx_byte;
			end
			if (count_q == mrc_pkg::count_t'(4)) begin
				value_nx[7:0] = rx_byte;
			end
			count_nx = count_q + mrc_pkg::count_t'(1);
		end

		received = {pair_nx[7:0], pair_nx[15:8]};
		if (count_nx < mrc_pkg::count_t'(mrc_pkg::MIN_FRAME_BYTES)) begin
			result.status = mrc_pkg::ST_SHORT;
		end else if (!header_nx) begin
			result.status = mrc_pkg::ST_HEADER;
		end else if (received != crc_nx) begin
			result.status = mrc_pkg::ST_CRC;
		end else begin
			result.status = mrc_pkg::ST_OK;
		end
		result.reading = (result.status == mrc_pkg::ST_OK) ? $signed(value_nx)
			: mrc_pkg::FAIL_READING;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= mrc_pkg::CRC_SEED;
			count_q <= '0;
			pair_q <= '0;
			header_q <= 1'b1;
			value_q <= '0;
		end else if (step) begin
			if (frame_end) begin
				crc_q <= mrc_pkg::CRC_SEED;
				count_q <= '0;
				pair_q <= '0;
				header_q <= 1'b1;
				value_q <= '0;
			end else begin
				crc_q <= crc_nx;
				count_q <= count_nx;
				pair_q <= pair_nx;
				header_q <= header_nx;
				value_q <= value_nx;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/modbus_response_checker.sv
`default_nettype none

// Channel  | Signals                                 | Direction
// ---------+-----------------------------------------+----------
// in       | in_valid, in_ready, rx_byte, frame_end  | sink
// out      | out_valid, out_ready, reading,          | source
//          | check_status                            |
// cfg      | cfg_valid, cfg_ready, cfg_index,        | sink
//          | cfg_data                                |
//
// One byte beat is taken every cycle unless a last-byte beat sits in the input
// register behind a stalled result, which blocks further beats. The CRC byte
// step, set by an eight-step unrolled shift of the 16-bit remainder, sits
// between the input register and the frame state, ahead of the result register.
// Reset restores the expected address 1 and function 3 and clears the frame.

module modbus_response_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               frame_end,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      reading,
	output logic [1:0]              check_status,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [7:0]         cfg_data
);

	logic [7:0] exp_addr_q;
	logic [7:0] exp_func_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       fire_s1;
	logic       out_free;

	mrc_pkg::frame_result_t result;
	mrc_pkg::frame_result_t result_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_addr_q <= mrc_pkg::RESET_ADDRESS;
			exp_func_q <= mrc_pkg::RESET_FUNCTION;
		end else if (cfg_valid && cfg_ready) begin
			unique case (mrc_pkg::cfg_reg_t'(cfg_index))
				mrc_pkg::REG_EXPECTED_ADDRESS: exp_addr_q <= cfg_data;
				mrc_pkg::REG_EXPECTED_FUNCTION: exp_func_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid || out_ready;
	assign fire_s1 = valid_s1 && (!end_s1 || out_free);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
			end_s1 <= frame_end;
		end
	end

	mrc_frame_track u_track (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (fire_s1),
		.rx_byte           (byte_s1),
		.frame_end         (end_s1),
		.expected_address  (exp_addr_q),
		.expected_function (exp_func_q),
		.result            (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= fire_s1 && end_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire_s1 && end_s1) begin
			result_q <= result;
		end
	end

	assign reading = result_q.reading;
	assign check_status = result_q.status;

endmodule

`default_nettype wire

// File: hdl/mrc_port_checker.sv
`default_nettype none

module mrc_port_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               frame_end,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [15:0] reading,
	input wire logic [1:0]         check_status
);

	// A stalled result beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reading) && $stable(check_status))
		else $error("result beat changed while stalled");

	// Any failed check reports the fail reading.
	a_fail_reading: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && check_status != mrc_pkg::ST_OK |-> reading == mrc_pkg::FAIL_READING)
		else $error("failed frame without fail reading");

	// A fresh result follows an accepted last-byte beat.
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && frame_end, 2))
		else $error("result beat without a last-byte beat");

	// A last-byte beat held behind a stalled result blocks further input.
	a_end_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && frame_end) ##1 (out_valid && !out_ready) |-> !in_ready)
		else $error("input taken while a frame end is held");

endmodule

bind modbus_response_checker mrc_port_checker u_mrc_port_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.frame_end    (frame_end),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.reading      (reading),
	.check_status (check_status)
);

`default_nettype wire

// File: test/modbus_response_checker_test.sv
`timescale 1ns / 1ps

module modbus_response_checker_test;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BEATS = 1350;
	localparam int MAX_PRINTS = 100;

	typedef enum int {
		RDY_ALWAYS,
		RDY_RANDOM,
		RDY_LONG
	} ready_mode_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] rx_byte;
	logic frame_end;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] reading;
	logic [1:0] check_status;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [7:0] cfg_data;

	modbus_response_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.reading(reading),
		.check_status(check_status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predicted frame state and register copies.
	logic [7:0] want_address;
	logic [7:0] want_function;
	logic [15:0] crc_acc;
	int beat_count;
	logic [15:0] pair_hold;
	logic hdr_ok;
	logic [15:0] word_hold;

	mrc_pkg::frame_result_t pending_results[$];
	logic [7:0] frame_buf[$];

	int mismatch_count;
	int cycle_count;
	int beats_sent;
	int burst_left;
	int burst_max;
	int gap_max;
	int stall_left;
	ready_mode_t ready_mode;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
		logic [15:0] r;
		logic fb;
		r = c;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ d[i];
			r = r >> 1;
			if (fb) begin
				r = r ^ mrc_pkg::CRC_POLY;
			end
		end
		return r;
	endfunction

	task automatic clear_frame_state();
		crc_acc = mrc_pkg::CRC_SEED;
		beat_count = 0;
		pair_hold = 16'h0000;
		hdr_ok = 1'b1;
		word_hold = 16'h0000;
	endtask

	task automatic predict_beat(input logic [7:0] b, input logic last);
		mrc_pkg::frame_result_t res;
		logic [15:0] sent_crc;
		if (beat_count < mrc_pkg::MAX_FRAME_BYTES) begin
			if (beat_count >= 2) begin
				crc_acc = crc_step(crc_acc, pair_hold[15:8]);
			end
			pair_hold = {pair_hold[7:0], b};
			if (beat_count == 0 && b != want_address) begin
				hdr_ok = 1'b0;
			end
			if (beat_count == 1 && b != want_function) begin
				hdr_ok = 1'b0;
			end
			if (beat_count == 3) begin
				word_hold[15:8] = b;
			end
			if (beat_count == 4) begin
				word_hold[7:0] = b;
			end
			beat_count++;
		end
		if (last) begin
			sent_crc = {pair_hold[7:0], pair_hold[15:8]};
			if (beat_count < mrc_pkg::MIN_FRAME_BYTES) begin
				res.status = mrc_pkg::ST_SHORT;
			end else if (!hdr_ok) begin
				res.status = mrc_pkg::ST_HEADER;
			end else if (sent_crc != crc_acc) begin
				res.status = mrc_pkg::ST_CRC;
			end else begin
				res.status = mrc_pkg::ST_OK;
			end
			res.reading = (res.status == mrc_pkg::ST_OK) ? word_hold : mrc_pkg::FAIL_READING;
			pending_results.push_back(res);
			clear_frame_state();
		end
	endtask

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTS) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		mrc_pkg::frame_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with none pending, reading %0d status %0d",
					reading, check_status));
			end else begin
				exp_res = pending_results.pop_front();
				if (reading !== exp_res.reading) begin
					report_mismatch($sformatf("reading %0d, expected %0d",
						reading, exp_res.reading));
				end
				if (check_status !== exp_res.status) begin
					report_mismatch($sformatf("check_status %0d, expected %0d",
						check_status, exp_res.status));
				end
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				case (ready_mode)
					RDY_ALWAYS: begin
						out_ready <= 1'b1;
					end
					RDY_RANDOM: begin
						out_ready <= ($urandom_range(0, 2) != 0);
					end
					default: begin
						if ($urandom_range(0, 15) == 0) begin
							stall_left = $urandom_range(1, 30);
							out_ready <= 1'b0;
						end else begin
							out_ready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic last);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, burst_max);
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_end <= last;
		do @(posedge clk); while (!in_ready);
		predict_beat(b, last);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic wait_for_results();
		stop_sending();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input mrc_pkg::cfg_reg_t idx, input logic [7:0] value);
		wait_for_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == mrc_pkg::REG_EXPECTED_ADDRESS) begin
			want_address = value;
		end else begin
			want_function = value;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic make_response(input logic [7:0] addr, input logic [7:0] func,
			input logic [15:0] value, input int extra);
		frame_buf.delete();
		frame_buf.push_back(addr);
		frame_buf.push_back(func);
		frame_buf.push_back(8'($urandom_range(0, 255)));
		frame_buf.push_back(value[15:8]);
		frame_buf.push_back(value[7:0]);
		repeat (extra) frame_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_crc();
		logic [15:0] c;
		c = mrc_pkg::CRC_SEED;
		foreach (frame_buf[i]) begin
			c = crc_step(c, frame_buf[i]);
		end
		frame_buf.push_back(c[7:0]);
		frame_buf.push_back(c[15:8]);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++) begin
			send_beat(frame_buf[i], i == frame_buf.size() - 1);
		end
		beats_sent += frame_buf.size();
	endtask

	task automatic send_good(input logic [15:0] value, input int extra);
		make_response(want_address, want_function, value, extra);
		add_crc();
		send_frame();
	endtask

	task automatic send_overlong(input int junk);
		make_response(want_address, want_function, 16'($urandom_range(0, 65535)), 25);
		add_crc();
		repeat (junk) frame_buf.push_back(8'($urandom_range(0, 255)));
		send_frame();
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 16'h0000;
			1: return 16'h7FFF;
			2: return 16'h8000;
			3: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic test_good_frames();
		ready_mode = RDY_ALWAYS;
		send_good(16'h1234, 0);
		send_good(16'h7FFF, 2);
		send_good(16'h8000, 0);
		send_good(16'hFFFF, 1);
		send_good(16'h0000, 0);
	endtask

	task automatic test_short_frames();
		frame_buf.delete();
		frame_buf.push_back(8'hFF);
		send_frame();
		make_response(want_address, want_function, 16'h0101, 0);
		frame_buf.push_back(8'h00);
		send_frame();
		make_response(~want_address, want_function, 16'h0202, 0);
		send_frame();
	endtask

	task automatic test_header_and_crc();
		make_response(8'h00, want_function, 16'h5555, 0);
		add_crc();
		send_frame();
		make_response(want_address, 8'h00, 16'hAAAA, 0);
		add_crc();
		send_frame();
		make_response(want_address, want_function, 16'h0F0F, 1);
		add_crc();
		frame_buf[frame_buf.size() - 1] ^= 8'h01;
		send_frame();
		make_response(~want_address, want_function, 16'hF0F0, 0);
		add_crc();
		frame_buf[frame_buf.size() - 2] ^= 8'h80;
		send_frame();
	endtask

	task automatic test_overlong_frames();
		ready_mode = RDY_RANDOM;
		send_overlong(0);
		send_overlong(1);
		send_overlong(6);
	endtask

	task automatic test_register_extremes();
		write_reg(mrc_pkg::REG_EXPECTED_ADDRESS, 8'h00);
		write_reg(mrc_pkg::REG_EXPECTED_FUNCTION, 8'hFF);
		send_good(16'h2468, 0);
		write_reg(mrc_pkg::REG_EXPECTED_ADDRESS, 8'hFF);
		write_reg(mrc_pkg::REG_EXPECTED_FUNCTION, 8'h00);
		send_good(16'h1357, 3);
		make_response(8'h01, 8'h03, 16'h4321, 0);
		add_crc();
		send_frame();
		write_reg(mrc_pkg::REG_EXPECTED_ADDRESS, mrc_pkg::RESET_ADDRESS);
		write_reg(mrc_pkg::REG_EXPECTED_FUNCTION, mrc_pkg::RESET_FUNCTION);
		send_good(16'h9999, 0);
	endtask

	task automatic test_drain_pause();
		ready_mode = RDY_LONG;
		burst_max = 3;
		gap_max = 4;
		send_good(pick_value(), 2);
		send_good(pick_value(), 0);
		wait_for_results();
		send_good(pick_value(), 1);
	endtask

	task automatic send_random_frame();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			send_good(pick_value(), ($urandom_range(0, 9) == 0) ? $urandom_range(0, 25)
				: $urandom_range(0, 4));
		end else if (pick < 70) begin
			make_response(want_address, want_function, pick_value(), $urandom_range(0, 6));
			add_crc();
			frame_buf[frame_buf.size() - 1 - $urandom_range(0, 1)] ^=
				8'($urandom_range(1, 255));
			send_frame();
		end else if (pick < 78) begin
			make_response(want_address, want_function, pick_value(), $urandom_range(0, 6));
			if ($urandom_range(0, 1) != 0) begin
				frame_buf[0] ^= 8'($urandom_range(1, 255));
			end else begin
				frame_buf[1] ^= 8'($urandom_range(1, 255));
			end
			add_crc();
			send_frame();
		end else if (pick < 84) begin
			make_response(want_address, want_function, pick_value(), 0);
			repeat ($urandom_range(0, 4)) frame_buf.pop_back();
			send_frame();
		end else if (pick < 94) begin
			frame_buf.delete();
			repeat ($urandom_range(1, 40)) frame_buf.push_back(8'($urandom_range(0, 255)));
			send_frame();
		end else begin
			send_overlong($urandom_range(0, 10));
		end
	endtask

	task automatic test_random_traffic();
		int phase_mark;
		phase_mark = beats_sent;
		while (beats_sent < RANDOM_BEATS + phase_mark) begin
			if ($urandom_range(0, 40) == 0) begin
				case ($urandom_range(0, 3))
					0: write_reg(mrc_pkg::REG_EXPECTED_ADDRESS, 8'($urandom_range(0, 255)));
					1: write_reg(mrc_pkg::REG_EXPECTED_FUNCTION, 8'($urandom_range(0, 255)));
					2: write_reg(mrc_pkg::REG_EXPECTED_ADDRESS,
						$urandom_range(0, 1) ? 8'h00 : 8'hFF);
					default: wait_for_results();
				endcase
			end
			if ($urandom_range(0, 15) == 0) begin
				ready_mode = ready_mode_t'($urandom_range(0, 2));
				burst_max = $urandom_range(1, 12);
				gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			end
			send_random_frame();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		frame_end = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = mrc_pkg::REG_EXPECTED_ADDRESS;
		cfg_data = 8'h00;
		mismatch_count = 0;
		cycle_count = 0;
		beats_sent = 0;
		burst_left = 0;
		burst_max = 1;
		gap_max = 0;
		stall_left = 0;
		ready_mode = RDY_ALWAYS;
		want_address = mrc_pkg::RESET_ADDRESS;
		want_function = mrc_pkg::RESET_FUNCTION;
		clear_frame_state();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_good_frames();
		test_short_frames();
		test_header_and_crc();
		test_overlong_frames();
		test_register_extremes();
		test_drain_pause();
		test_random_traffic();

		wait_for_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: modbus_response_checker.f
hdl/mrc_pkg.sv
hdl/mrc_frame_track.sv
hdl/modbus_response_checker.sv
hdl/mrc_port_checker.sv
test/modbus_response_checker_test.sv
